>>> sv/tcw_pkg.sv
// Package with the shared constants, types and helpers of the text console window.
package tcw_pkg;

	localparam int DISPLAY_COLS = 40;
	localparam int DISPLAY_ROWS = 16;
	localparam int TAB_STOP = 8;
	localparam int CELLS = DISPLAY_COLS * DISPLAY_ROWS;
	localparam int COL_W = 6;
	localparam int ROW_W = 4;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CODE_W = 8;
	localparam int TAB_W = $clog2(TAB_STOP + 1);

	// Command codes.
	localparam logic [1:0] CMD_PUT = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	// Register indexes.
	localparam logic [1:0] REG_LEFT = 2'd0;
	localparam logic [1:0] REG_TOP = 2'd1;
	localparam logic [1:0] REG_RIGHT = 2'd2;
	localparam logic [1:0] REG_BOTTOM = 2'd3;

	// Control characters.
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input transaction and clamp the cursor
		logic wr_code;    // write the character code at the cursor
		logic adv_col;    // advance the column after a write
		logic row_adv;    // advance the row (LF or wrap)
		logic home_col;   // carriage return
		logic home_all;   // cursor to window origin
		logic mov_start;  // start a row-copy pass of a scroll
		logic clr_start;  // start a clearing pass
		logic step;       // one cell of a walk: issue read or write
		logic peek_rd;    // issue the read of a peek
		logic peek_cap;   // capture the peek data
		logic tab_dec;    // one space of a tab done
		logic sweep_clr;  // clearing sweep after reset
	} tcw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_last;  // current cell is the last of the walk
		logic row_wrap;   // column advance reaches the window width
		logic row_over;   // row advance leaves the window
		logic tab_last;   // last space of a tab
		logic sweep_last; // last cell of the reset sweep
	} tcw_sts_t;

	// Cell address of a display column and row.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		logic [ADDR_W+1:0] a;
		a = (ADDR_W + 2)'(r) * (ADDR_W + 2)'(DISPLAY_COLS) + (ADDR_W + 2)'(c);
		return a[ADDR_W-1:0];
	endfunction

endpackage

>>> sv/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 640
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/tcw_datapath.sv
// Datapath of the text console window: window decode, cursor, walk counters and display memory.
module tcw_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [tcw_pkg::COL_W-1:0]        window_left,
	input  logic [tcw_pkg::ROW_W-1:0]        window_top,
	input  logic [tcw_pkg::COL_W-1:0]        window_right,
	input  logic [tcw_pkg::ROW_W-1:0]        window_bottom,
	input  logic [7:0]                       char_in,
	input  logic [tcw_pkg::COL_W-1:0]        peek_col,
	input  logic [tcw_pkg::ROW_W-1:0]        peek_row,
	input  tcw_pkg::tcw_cmd_t                cmd,
	output tcw_pkg::tcw_sts_t                sts,
	output logic [tcw_pkg::COL_W-1:0]        cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]        cursor_row,
	output logic [7:0]                       peek_code,
	output logic                             window_bad
);

	localparam int CW = tcw_pkg::COL_W;
	localparam int RW = tcw_pkg::ROW_W;
	localparam int AW = tcw_pkg::ADDR_W;

	logic bad;
	logic [CW-1:0] w_left, w_cols_m1;
	logic [RW-1:0] w_top, w_rows_m1;
	logic [CW-1:0] wl_q, wc_q, col_q;
	logic [RW-1:0] wt_q, wr_q, row_q;
	logic bad_q;
	logic [7:0] ch_q;
	logic [CW-1:0] pc_q;
	logic [RW-1:0] pr_q;
	logic [tcw_pkg::TAB_W-1:0] tab_q;
	logic [CW-1:0] wcol_q;
	logic [RW-1:0] wrow_q;
	logic [RW-1:0] wlast_q;
	logic wmove_q, wrd_q;
	logic [AW-1:0] sweep_q;
	logic peek_ok_q;
	logic [CW-1:0] clamp_col;
	logic [RW-1:0] clamp_row;
	logic we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] wdata, rdata;

	// Effective window from the registers.
	always_comb begin
		bad = !(window_left < window_right && window_top < window_bottom &&
			32'(window_right) < tcw_pkg::DISPLAY_COLS &&
			32'(window_bottom) < tcw_pkg::DISPLAY_ROWS);
		if (bad) begin
			w_left = '0;
			w_top = '0;
			w_cols_m1 = CW'(tcw_pkg::DISPLAY_COLS - 1);
			w_rows_m1 = RW'(tcw_pkg::DISPLAY_ROWS - 1);
		end else begin
			w_left = window_left;
			w_top = window_top;
			w_cols_m1 = window_right - window_left;
			w_rows_m1 = window_bottom - window_top;
		end
		clamp_col = (col_q > w_cols_m1) ? w_cols_m1 : col_q;
		clamp_row = (row_q > w_rows_m1) ? w_rows_m1 : row_q;
	end

	// Status toward the controller.
	always_comb begin
		sts.row_wrap = (col_q == wc_q);
		sts.row_over = (row_q == wr_q);
		sts.tab_last = (tab_q == tcw_pkg::TAB_W'(1));
		sts.walk_last = (wcol_q == wc_q) && (wrow_q == wlast_q);
		sts.sweep_last = (32'(sweep_q) == tcw_pkg::CELLS - 1);
	end

	// Cursor, captured transaction and walk counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sweep_q <= '0;
			tab_q <= '0;
			wcol_q <= '0;
			wrow_q <= '0;
			wlast_q <= '0;
			wmove_q <= 1'b0;
			wrd_q <= 1'b0;
		end else begin
			if (cmd.sweep_clr) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (cmd.load) begin
				col_q <= clamp_col;
				row_q <= clamp_row;
				tab_q <= tcw_pkg::TAB_W'(tcw_pkg::TAB_STOP) -
					tcw_pkg::TAB_W'(clamp_col % CW'(tcw_pkg::TAB_STOP));
			end
			if (cmd.tab_dec) begin
				tab_q <= tab_q - tcw_pkg::TAB_W'(1);
			end
			if (cmd.adv_col) begin
				col_q <= sts.row_wrap ? '0 : col_q + CW'(1);
			end
			if (cmd.home_col) begin
				col_q <= '0;
			end
			if (cmd.row_adv && !sts.row_over) begin
				row_q <= row_q + RW'(1);
			end
			if (cmd.home_all) begin
				col_q <= '0;
				row_q <= '0;
			end
			// A scroll copies rows 1..last up, then blanks the last row.
			if (cmd.mov_start) begin
				wcol_q <= '0;
				wrow_q <= '0;
				wmove_q <= (wr_q != '0);
				wlast_q <= wr_q;
				wrd_q <= 1'b1;
			end
			if (cmd.clr_start) begin
				wcol_q <= '0;
				wrow_q <= '0;
				wmove_q <= 1'b0;
				wlast_q <= wr_q;
				wrd_q <= 1'b0;
			end
			if (cmd.step) begin
				if (wmove_q && wrd_q) begin
					wrd_q <= 1'b0;
				end else begin
					wrd_q <= wmove_q;
					if (wcol_q == wc_q) begin
						wcol_q <= '0;
						wrow_q <= wrow_q + RW'(1);
						if (wmove_q && (wrow_q + RW'(1) == wr_q)) begin
							wmove_q <= 1'b0;
							wrd_q <= 1'b0;
						end
					end else begin
						wcol_q <= wcol_q + CW'(1);
					end
				end
			end
		end
	end

	// Window snapshot and payload of the transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wl_q <= w_left;
			wt_q <= w_top;
			wc_q <= w_cols_m1;
			wr_q <= w_rows_m1;
			bad_q <= bad;
			ch_q <= char_in;
			pc_q <= peek_col;
			pr_q <= peek_row;
		end
		if (cmd.peek_rd) begin
			peek_ok_q <= 32'(pc_q) < tcw_pkg::DISPLAY_COLS &&
				32'(pr_q) < tcw_pkg::DISPLAY_ROWS;
		end
	end

	// Memory port selection.
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = tcw_pkg::cell_addr(wt_q + row_q, wl_q + col_q);
		wdata = ch_q - tcw_pkg::CH_SPACE;
		raddr = tcw_pkg::cell_addr(wt_q + wrow_q + RW'(1), wl_q + wcol_q);
		if (cmd.sweep_clr) begin
			we = 1'b1;
			waddr = sweep_q;
			wdata = '0;
		end else if (cmd.wr_code) begin
			we = 1'b1;
			if (ch_q == tcw_pkg::CH_TAB) begin
				wdata = '0;
			end
		end else if (cmd.step) begin
			if (wmove_q && wrd_q) begin
				re = 1'b1;
			end else begin
				we = 1'b1;
				waddr = tcw_pkg::cell_addr(wt_q + wrow_q, wl_q + wcol_q);
				wdata = wmove_q ? rdata : '0;
			end
		end else if (cmd.peek_rd) begin
			re = 1'b1;
			raddr = tcw_pkg::cell_addr(pr_q, pc_q);
		end
	end

	tcw_ram #(.WIDTH(tcw_pkg::CODE_W), .DEPTH(tcw_pkg::CELLS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Result fields.
	assign cursor_col = wl_q + col_q;
	assign cursor_row = wt_q + row_q;
	assign peek_code = (cmd.peek_cap && peek_ok_q) ? rdata : '0;
	assign window_bad = bad_q;

endmodule

>>> sv/tcw_ctrl.sv
// Controller state machine of the text console window.
module tcw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [7:0]        char_in,
	output logic              out_valid,
	input  logic              out_stall,
	input  tcw_pkg::tcw_sts_t sts,
	output tcw_pkg::tcw_cmd_t cmd,
	output logic              res_load,
	output logic              busy
);

	typedef enum logic [7:0] {
		ST_SWEEP = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_EXEC  = 8'b0000_0100,
		ST_PUT   = 8'b0000_1000,
		ST_ROW   = 8'b0001_0000,
		ST_WALK  = 8'b0010_0000,
		ST_PEEK  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] cmd_q;
	logic [7:0] ch_q;
	logic clear_q;
	logic tab_more_q;
	logic ovalid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		res_load = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.sweep_clr = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid && !ovalid_q) begin
					cmd.load = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd_q == tcw_pkg::CMD_PUT) begin
					if (ch_q == tcw_pkg::CH_CR) begin
						cmd.home_col = 1'b1;
						state_d = ST_DONE;
					end else if (ch_q == tcw_pkg::CH_LF) begin
						state_d = ST_ROW;
					end else begin
						state_d = ST_PUT;
					end
				end else if (cmd_q == tcw_pkg::CMD_CLEAR) begin
					cmd.clr_start = 1'b1;
					state_d = ST_WALK;
				end else if (cmd_q == tcw_pkg::CMD_PEEK) begin
					cmd.peek_rd = 1'b1;
					state_d = ST_PEEK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PUT: begin
				cmd.wr_code = 1'b1;
				cmd.adv_col = 1'b1;
				if (ch_q == tcw_pkg::CH_TAB) begin
					cmd.tab_dec = 1'b1;
				end
				if (sts.row_wrap) begin
					state_d = ST_ROW;
				end else if (ch_q == tcw_pkg::CH_TAB && !sts.tab_last) begin
					state_d = ST_PUT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ROW: begin
				cmd.row_adv = 1'b1;
				if (sts.row_over) begin
					cmd.mov_start = 1'b1;
					state_d = ST_WALK;
				end else if (tab_more_q) begin
					state_d = ST_PUT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (sts.walk_last) begin
					if (clear_q) begin
						cmd.home_all = 1'b1;
						state_d = ST_DONE;
					end else if (tab_more_q) begin
						state_d = ST_PUT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_PEEK: begin
				cmd.peek_cap = 1'b1;
				res_load = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DONE: begin
				res_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, captured command and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			cmd_q <= '0;
			ch_q <= '0;
			clear_q <= 1'b0;
			tab_more_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cmd_q <= command;
				ch_q <= char_in;
				clear_q <= (command == tcw_pkg::CMD_CLEAR);
				tab_more_q <= 1'b0;
			end
			// A tab that still has spaces after this one resumes after the wrap.
			if (cmd.wr_code) begin
				tab_more_q <= (ch_q == tcw_pkg::CH_TAB) && !sts.tab_last;
			end
			if (res_load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign in_stall = !(state_q == ST_IDLE) || ovalid_q;
	assign out_valid = ovalid_q;
	assign busy = (state_q != ST_IDLE);

endmodule

>>> sv/text_console_window_core.sv
// Top level of the text console window: configuration registers, controller and datapath.
// Each transaction takes its turn alone. A carriage return or a read of a cell goes from
// the execute state to the result; a printed character first writes its cell, a tab one
// space after another. A wrap that scrolls walks the window, copying rows up and blanking
// the last; a clear walks every cell of the window. After reset a clearing pass over the
// whole display runs before the first transaction. A result is held in an output register
// until taken; the next transaction enters once that register has emptied.
module text_console_window_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [7:0]                cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                command,
	input  logic [7:0]                char_in,
	input  logic [tcw_pkg::COL_W-1:0] peek_col,
	input  logic [tcw_pkg::ROW_W-1:0] peek_row,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [tcw_pkg::COL_W-1:0] cursor_col,
	output logic [tcw_pkg::ROW_W-1:0] cursor_row,
	output logic [7:0]                peek_code,
	output logic                      did_scroll,
	output logic                      window_bad
);

	logic [tcw_pkg::COL_W-1:0] left_q, right_q;
	logic [tcw_pkg::ROW_W-1:0] top_q, bottom_q;
	tcw_pkg::tcw_cmd_t cmd;
	tcw_pkg::tcw_sts_t sts;
	logic res_load, busy;
	logic scroll_q;
	logic [tcw_pkg::COL_W-1:0] dp_col, col_q;
	logic [tcw_pkg::ROW_W-1:0] dp_row, row_q;
	logic [7:0] dp_peek, peek_q;
	logic dp_bad, bad_q;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			top_q <= '0;
			right_q <= tcw_pkg::COL_W'(tcw_pkg::DISPLAY_COLS - 1);
			bottom_q <= tcw_pkg::ROW_W'(tcw_pkg::DISPLAY_ROWS - 1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tcw_pkg::REG_LEFT:   left_q <= cfg_data[tcw_pkg::COL_W-1:0];
				tcw_pkg::REG_TOP:    top_q <= cfg_data[tcw_pkg::ROW_W-1:0];
				tcw_pkg::REG_RIGHT:  right_q <= cfg_data[tcw_pkg::COL_W-1:0];
				tcw_pkg::REG_BOTTOM: bottom_q <= cfg_data[tcw_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.char_in   (char_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.res_load  (res_load),
		.busy      (busy)
	);

	tcw_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.window_left   (left_q),
		.window_top    (top_q),
		.window_right  (right_q),
		.window_bottom (bottom_q),
		.char_in       (char_in),
		.peek_col      (peek_col),
		.peek_row      (peek_row),
		.cmd           (cmd),
		.sts           (sts),
		.cursor_col    (dp_col),
		.cursor_row    (dp_row),
		.peek_code     (dp_peek),
		.window_bad    (dp_bad)
	);

	// Scroll flag of the transaction in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_q <= 1'b0;
		end else if (cmd.load) begin
			scroll_q <= 1'b0;
		end else if (cmd.mov_start) begin
			scroll_q <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (res_load) begin
			col_q <= dp_col;
			row_q <= dp_row;
			peek_q <= dp_peek;
			bad_q <= dp_bad;
			did_scroll <= scroll_q;
		end
	end

	assign cursor_col = col_q;
	assign cursor_row = row_q;
	assign peek_code = peek_q;
	assign window_bad = bad_q;

	// A result is only loaded by a busy controller.
	assert property (@(posedge clk) disable iff (!arst_n) res_load |-> busy)
		else $error("result loaded while idle");
	// No transaction is taken while a result is waiting.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("input taken with result pending");
	// A scroll never starts with a clear.
	assert property (@(posedge clk) disable iff (!arst_n) !(cmd.mov_start && cmd.clr_start))
		else $error("scroll and clear started together");

endmodule
